[rtl/lru_pr_pkg.sv]
`timescale 1ns / 1ps

package lru_pr_pkg;

   localparam int FRAMES_DEFAULT    = 8;
   localparam int PAGE_BITS_DEFAULT = 16;

   localparam int PAGE_W  = 16;
   localparam int SLOT_W  = 3;
   localparam int TOTAL_W = 32;
   localparam int ACT_W   = 4;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] frame_slot;
      logic              evicted_valid;
      logic [PAGE_W-1:0] evicted_page;
   } lookup_type;

endpackage

[rtl/lru_pr_in_reg.sv]
`timescale 1ns / 1ps

module lru_pr_in_reg
   import lru_pr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [PAGE_W-1:0] req_page,
   input  logic              advance,
   output logic              beat_valid,
   output logic [PAGE_W-1:0] beat_page
);

   logic              valid_ff;
   logic              valid_in;
   logic [PAGE_W-1:0] page_ff;

   assign req_ready  = !valid_ff || advance;
   assign beat_valid = valid_ff;
   assign beat_page  = page_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         page_ff <= req_page;
      end
   end

endmodule

[rtl/lru_pr_frame_table.sv]
`timescale 1ns / 1ps

module lru_pr_frame_table
   import lru_pr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEFAULT,
   parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [ACT_W-1:0]  csr_data,
   input  logic              advance,
   input  logic [PAGE_W-1:0] beat_page,
   output lookup_type        lookup
);

   localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int ACT_RESET = (FRAMES < 8) ? FRAMES : 8;

   logic [PAGE_BITS-1:0] page_ff  [FRAMES];
   logic [RANK_W-1:0]    rank_ff  [FRAMES];
   logic [RANK_W-1:0]    rank_in  [FRAMES];
   logic [FRAMES-1:0]    valid_ff;
   logic [FRAMES-1:0]    valid_in;
   logic [ACT_W-1:0]     act_ff;
   logic [ACT_W-1:0]     act_in;
   logic [ACT_W-1:0]     act_m1;
   logic [FRAMES-1:0]    active;
   logic [PAGE_BITS-1:0] page_m;

   logic                 hit;
   logic                 found_empty;
   logic [IDX_W-1:0]     hit_idx;
   logic [IDX_W-1:0]     empty_idx;
   logic [IDX_W-1:0]     victim_idx;
   logic [IDX_W-1:0]     slot;
   logic                 ev_valid;

   assign page_m = PAGE_BITS'(beat_page);
   assign act_m1 = act_ff - 1'b1;

   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         active[i] = (i < int'(act_ff));
      end
   end

   // clamp the written frame count into 1..FRAMES
   always_comb begin
      act_in = act_ff;
      if (csr_write) begin
         priority if (csr_data == '0) begin
            act_in = ACT_W'(1);
         end else if (int'(csr_data) > FRAMES) begin
            act_in = ACT_W'(FRAMES);
         end else begin
            act_in = csr_data;
         end
      end
   end

   always_comb begin
      hit         = 1'b0;
      found_empty = 1'b0;
      hit_idx     = '0;
      empty_idx   = '0;
      victim_idx  = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (active[i] && valid_ff[i] && page_ff[i] == page_m) begin
            hit     = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (active[i] && !valid_ff[i]) begin
            found_empty = 1'b1;
            empty_idx   = IDX_W'(i);
         end
         if (active[i] && valid_ff[i] && int'(rank_ff[i]) == int'(act_m1)) begin
            victim_idx = IDX_W'(i);
         end
      end
      priority if (hit) begin
         slot = hit_idx;
      end else if (found_empty) begin
         slot = empty_idx;
      end else begin
         slot = victim_idx;
      end
      ev_valid = !hit && !found_empty;
   end

   always_comb begin
      lookup.hit           = hit;
      lookup.frame_slot    = SLOT_W'(slot);
      lookup.evicted_valid = ev_valid;
      lookup.evicted_page  = ev_valid ? PAGE_W'(page_ff[victim_idx]) : '0;
   end

   // age frames younger than the touched one; an empty frame ages everything
   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < FRAMES; i++) begin
         rank_in[i] = rank_ff[i];
         if (csr_write) begin
            valid_in[i] = 1'b0;
            rank_in[i]  = '0;
         end else if (advance) begin
            if (IDX_W'(i) == slot) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else if (active[i] && valid_ff[i]
                         && (!valid_ff[slot] || rank_ff[i] < rank_ff[slot])
                         && rank_ff[i] != RANK_W'(FRAMES - 1)) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         act_ff   <= ACT_W'(ACT_RESET);
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         act_ff   <= act_in;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && !csr_write) begin
         page_ff[slot] <= page_m;
      end
   end

endmodule

[rtl/lru_pr_rsp_reg.sv]
`timescale 1ns / 1ps

module lru_pr_rsp_reg
   import lru_pr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  lookup_type         lookup,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [SLOT_W-1:0]  rsp_frame_slot,
   output logic               rsp_evicted_valid,
   output logic [PAGE_W-1:0]  rsp_evicted_page,
   output logic [TOTAL_W-1:0] rsp_hit_total,
   output logic [TOTAL_W-1:0] rsp_fault_total
);

   logic               valid_ff;
   logic               valid_in;
   lookup_type         data_ff;
   logic [TOTAL_W-1:0] hit_total_ff;
   logic [TOTAL_W-1:0] hit_total_in;
   logic [TOTAL_W-1:0] fault_total_ff;
   logic [TOTAL_W-1:0] fault_total_in;

   always_comb begin
      valid_in       = valid_ff;
      hit_total_in   = hit_total_ff;
      fault_total_in = fault_total_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (advance) begin
         valid_in = 1'b1;
         if (lookup.hit) begin
            if (hit_total_ff != '1) begin
               hit_total_in = hit_total_ff + 1'b1;
            end
         end else if (fault_total_ff != '1) begin
            fault_total_in = fault_total_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         hit_total_ff   <= '0;
         fault_total_ff <= '0;
      end else begin
         valid_ff       <= valid_in;
         hit_total_ff   <= hit_total_in;
         fault_total_ff <= fault_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= lookup;
      end
   end

   // totals only move on advance, so they hold with the waiting beat
   assign rsp_valid         = valid_ff;
   assign rsp_hit           = data_ff.hit;
   assign rsp_frame_slot    = data_ff.frame_slot;
   assign rsp_evicted_valid = data_ff.evicted_valid;
   assign rsp_evicted_page  = data_ff.evicted_page;
   assign rsp_hit_total     = hit_total_ff;
   assign rsp_fault_total   = fault_total_ff;

endmodule

[rtl/lru_page_replacement.sv]
`timescale 1ns / 1ps

// LRU page replacement unit.
// Request channel (req_valid/req_ready/req_page) carries one page reference
// per beat. Response channel (rsp_valid/rsp_ready/rsp_*) returns one beat per
// reference: hit or fault, the frame now holding the page, the evicted page if
// any, and saturating hit and fault totals.
// Configuration: pulse csr_write with csr_data to set the number of active
// frames (clamped to 1..FRAMES); this empties every frame, totals are kept.
// An accepted reference passes through the input register, the lookup and
// the response register. Throughput: one reference per cycle while the
// response channel does not stall; the frame lookup and rank update are
// a single combinational pass between the two registers.
// Reset: all frames empty, totals zero, active frame count min(FRAMES, 8).
// Stall: while rsp_ready is low the response register holds its beat, the
// input register holds one more reference, and req_ready then drops.

module lru_page_replacement
   import lru_pr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEFAULT,
   parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [PAGE_W-1:0]  req_page,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [SLOT_W-1:0]  rsp_frame_slot,
   output logic               rsp_evicted_valid,
   output logic [PAGE_W-1:0]  rsp_evicted_page,
   output logic [TOTAL_W-1:0] rsp_hit_total,
   output logic [TOTAL_W-1:0] rsp_fault_total,
   input  logic               csr_write,
   input  logic [ACT_W-1:0]   csr_data
);

   logic              beat_valid;
   logic [PAGE_W-1:0] beat_page;
   logic              advance;
   lookup_type        lookup;

   assign advance = beat_valid && (!rsp_valid || rsp_ready);

   lru_pr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_page   (req_page),
      .advance    (advance),
      .beat_valid (beat_valid),
      .beat_page  (beat_page)
   );

   lru_pr_frame_table #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_frame_table (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .advance   (advance),
      .beat_page (beat_page),
      .lookup    (lookup)
   );

   lru_pr_rsp_reg u_rsp_reg (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .lookup            (lookup),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_fault_total   (rsp_fault_total)
   );

endmodule

[tb/lru_pr_checker.sv]
`timescale 1ns / 1ps

module lru_pr_checker
   import lru_pr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [PAGE_W-1:0]  req_page,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_hit,
   input  logic [SLOT_W-1:0]  rsp_frame_slot,
   input  logic               rsp_evicted_valid,
   input  logic [PAGE_W-1:0]  rsp_evicted_page,
   input  logic [TOTAL_W-1:0] rsp_hit_total,
   input  logic [TOTAL_W-1:0] rsp_fault_total,
   input  logic               csr_write,
   input  logic [ACT_W-1:0]   csr_data,
   output int                 fail_count,
   output int                 pending_count,
   output int                 refs_seen,
   output int                 hits_seen,
   output int                 evicts_seen
);

   localparam int NFRAMES = FRAMES_DEFAULT;

   typedef struct {
      lookup_type         lk;
      logic [TOTAL_W-1:0] hits;
      logic [TOTAL_W-1:0] faults;
   } outcome_type;

   logic [PAGE_W-1:0]  page_of [NFRAMES];
   bit                 held    [NFRAMES];
   logic [SLOT_W-1:0]  age     [NFRAMES];
   logic [TOTAL_W-1:0] hit_sum;
   logic [TOTAL_W-1:0] fault_sum;
   int                 active;
   outcome_type        lookups_due [$];
   int                 mismatches = 0;
   int                 n_refs     = 0;
   int                 n_hits     = 0;
   int                 n_evicts   = 0;

   function automatic void empty_all();
      int i;
      for (i = 0; i < NFRAMES; i++) begin
         held[i] = 1'b0;
         age[i]  = '0;
      end
   endfunction

   function automatic outcome_type resolve_reference(input logic [PAGE_W-1:0] pg);
      outcome_type o;
      int          i;
      int          slot;
      int          prior;
      bit          found;
      bit          empty;
      o.lk  = '0;
      slot  = 0;
      found = 1'b0;
      empty = 1'b0;
      for (i = 0; i < active; i++)
         if (!found && held[i] && page_of[i] == pg) begin
            found = 1'b1;
            slot  = i;
         end
      if (found) begin
         if (hit_sum != '1) hit_sum++;
      end else begin
         for (i = 0; i < active; i++)
            if (!empty && !held[i]) begin
               empty = 1'b1;
               slot  = i;
            end
         if (!empty) begin
            slot = 0;
            for (i = 1; i < active; i++)
               if (age[i] > age[slot]) slot = i;
            o.lk.evicted_valid = 1'b1;
            o.lk.evicted_page  = page_of[slot];
         end
         if (fault_sum != '1) fault_sum++;
      end
      prior = held[slot] ? int'(age[slot]) : NFRAMES;
      for (i = 0; i < active; i++)
         if (i != slot && held[i] && int'(age[i]) < prior && int'(age[i]) < NFRAMES - 1)
            age[i]++;
      age[slot]     = '0;
      held[slot]    = 1'b1;
      page_of[slot] = pg;
      o.lk.hit        = found;
      o.lk.frame_slot = SLOT_W'(slot);
      o.hits          = hit_sum;
      o.faults        = fault_sum;
      return o;
   endfunction

   function automatic void compare_field(input string fld, input logic [TOTAL_W-1:0] want,
                                         input logic [TOTAL_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
      end
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         empty_all();
         hit_sum   = '0;
         fault_sum = '0;
         active    = NFRAMES;
         lookups_due.delete();
      end else begin
         if (csr_write) begin
            if (csr_data == 0)
               active = 1;
            else if (int'(csr_data) > NFRAMES)
               active = NFRAMES;
            else
               active = int'(csr_data);
            empty_all();
         end
         if (rsp_valid && rsp_ready) begin
            if (lookups_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response beat with no reference outstanding", $time);
            end else begin
               want = lookups_due.pop_front();
               compare_field("hit", TOTAL_W'(want.lk.hit), TOTAL_W'(rsp_hit));
               compare_field("frame_slot", TOTAL_W'(want.lk.frame_slot),
                             TOTAL_W'(rsp_frame_slot));
               compare_field("evicted_valid", TOTAL_W'(want.lk.evicted_valid),
                             TOTAL_W'(rsp_evicted_valid));
               compare_field("evicted_page", TOTAL_W'(want.lk.evicted_page),
                             TOTAL_W'(rsp_evicted_page));
               compare_field("hit_total", want.hits, rsp_hit_total);
               compare_field("fault_total", want.faults, rsp_fault_total);
            end
            if (rsp_hit === 1'b1) n_hits++;
            if (rsp_evicted_valid === 1'b1) n_evicts++;
         end
         if (req_valid && req_ready) begin
            want = resolve_reference(req_page);
            lookups_due.push_back(want);
            n_refs++;
         end
      end
      fail_count    <= mismatches;
      pending_count <= lookups_due.size();
      refs_seen     <= n_refs;
      hits_seen     <= n_hits;
      evicts_seen   <= n_evicts;
   end

endmodule

[tb/tb_lru_page_replacement.sv]
`timescale 1ns / 1ps

module tb_lru_page_replacement;
   import lru_pr_pkg::*;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [PAGE_W-1:0]  req_page  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_hit;
   logic [SLOT_W-1:0]  rsp_frame_slot;
   logic               rsp_evicted_valid;
   logic [PAGE_W-1:0]  rsp_evicted_page;
   logic [TOTAL_W-1:0] rsp_hit_total;
   logic [TOTAL_W-1:0] rsp_fault_total;
   logic               csr_write = 1'b0;
   logic [ACT_W-1:0]   csr_data  = '0;

   int fail_count;
   int pending_count;
   int refs_seen;
   int hits_seen;
   int evicts_seen;

   bit idle_on         = 1'b0;
   bit long_stall_req  = 1'b0;
   bit long_stall_done = 1'b0;
   int rx_wait         = 0;
   int settings_done   = 0;

   always #2 clock = ~clock;

   lru_page_replacement u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page          (req_page),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_fault_total   (rsp_fault_total),
      .csr_write         (csr_write),
      .csr_data          (csr_data)
   );

   lru_pr_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page          (req_page),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_fault_total   (rsp_fault_total),
      .csr_write         (csr_write),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .refs_seen         (refs_seen),
      .hits_seen         (hits_seen),
      .evicts_seen       (evicts_seen)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait   <= 0;
      end else if (rx_wait > 0) begin
         rx_wait   <= rx_wait - 1;
         rsp_ready <= 1'b0;
      end else if (long_stall_req && !long_stall_done) begin
         // hold off long enough for the block to back up into its input
         rx_wait         <= 300;
         long_stall_done <= 1'b1;
         rsp_ready       <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rx_wait   <= $urandom_range(0, 15);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_page(input logic [PAGE_W-1:0] pg);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_page  <= pg;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_frames(input logic [ACT_W-1:0] v);
      drain();
      csr_write <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      settings_done++;
   endtask

   task automatic run_phase(input int n);
      logic [PAGE_W-1:0] pool [12];
      int                pool_n;
      int                k;
      pool_n = $urandom_range(1, 12);
      for (k = 0; k < pool_n; k++) pool[k] = PAGE_W'($urandom_range(0, 16'hFFFF));
      for (k = 0; k < n; k++)
         if ($urandom_range(0, 6) == 0)
            send_page(PAGE_W'($urandom_range(0, 16'hFFFF)));
         else
            send_page(pool[$urandom_range(0, pool_n - 1)]);
   endtask

   initial begin
      logic [PAGE_W-1:0] opening [16] = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0001,
                                          16'h0002, 16'h0003, 16'h0004, 16'h0005,
                                          16'h0006, 16'hFFFF, 16'h0007, 16'h8000,
                                          16'h7FFF, 16'h0000, 16'hAAAA, 16'h5555};
      logic [ACT_W-1:0]  phase_frames [12] = '{4'd3, 4'd8, 4'd2, 4'd9, 4'd5, 4'd1,
                                               4'd7, 4'd4, 4'd6, 4'd12, 4'd8, 4'd0};
      int k;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on <= 1'b1;

      for (k = 0; k < 16; k++) send_page(opening[k]);
      write_frames(4'd1);
      send_page(16'h0005);
      send_page(16'h0005);
      send_page(16'h0006);
      send_page(16'h0005);
      write_frames(4'd0);
      send_page(16'h0009);
      send_page(16'h0009);
      write_frames(4'd15);

      for (k = 0; k < 12; k++) begin
         write_frames(phase_frames[k]);
         idle_on <= (k % 4 != 2) && (k != 11);
         if (k == 1) long_stall_req <= 1'b1;
         run_phase(40);
      end

      drain();
      $display("Sent %0d page references across %0d frame-count settings,",
               refs_seen, settings_done);
      $display("including a long response stall; saw %0d hits and %0d evictions.",
               hits_seen, evicts_seen);
      if (fail_count == 0 && pending_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #1_600_000;
      $display("Verification failed");
      $finish;
   end

endmodule

[lru_page_replacement.f]
rtl/lru_pr_pkg.sv
rtl/lru_pr_in_reg.sv
rtl/lru_pr_frame_table.sv
rtl/lru_pr_rsp_reg.sv
rtl/lru_page_replacement.sv
tb/lru_pr_checker.sv
tb/tb_lru_page_replacement.sv
